FILE: rtl/tbs_pkg.sv
// tbs_pkg: shared types, sizes and opcodes of the bilinear texel sampler
// no dependencies; used by every module of the block by scoped names
`default_nettype none

package tbs_pkg;

  // texture geometry
  localparam int unsigned MAX_DIM   = 256;
  localparam int unsigned DIM_W     = $clog2(MAX_DIM);
  localparam int unsigned SIZE_W    = DIM_W + 1;
  localparam int unsigned ADDR_W    = 2 * DIM_W;
  localparam int unsigned TEX_DEPTH = MAX_DIM * MAX_DIM;
  localparam int unsigned TEXEL_W   = 8;

  // coordinate and blend arithmetic
  localparam int unsigned COORD_W   = 16;
  localparam int unsigned FRAC_W    = 8;
  localparam int unsigned SCALE_W   = COORD_W + DIM_W;
  localparam int unsigned WONE_W    = FRAC_W + 1;
  localparam int unsigned WGT_W     = 2 * FRAC_W + 1;
  localparam int unsigned PROD_W    = TEXEL_W + 2 * FRAC_W;
  localparam int unsigned SUM_W     = PROD_W + 2;
  localparam int unsigned RES_W     = 16;

  // four taps, one store copy each
  localparam int unsigned TAPS      = 4;

  // result queue
  localparam int unsigned QDEPTH    = 8;
  localparam int unsigned QPTR_W    = $clog2(QDEPTH);
  localparam int unsigned QCNT_W    = QPTR_W + 1;

  // stream and register port widths
  localparam int unsigned IN_DATA_W = 64;
  localparam int unsigned IN_USER_W = 2;
  localparam int unsigned APB_DW    = 32;
  localparam int unsigned APB_AW    = 3;

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_POINT  = 2'd1,
    OP_SAMPLE = 2'd2,
    OP_RSVD   = 2'd3
  } op_t;

  // per-stage control
  typedef struct packed {
    logic vld;
    op_t  op;
    logic filt;
  } ctl_t;

  // requests to the four store copies
  typedef struct packed {
    logic                          we;
    logic [ADDR_W-1:0]             waddr;
    logic [TEXEL_W-1:0]            wdata;
    logic [TAPS-1:0][ADDR_W-1:0]   raddr;
  } ram_req_t;

  // result queue status
  typedef struct packed {
    logic              full;
    logic [QCNT_W-1:0] count;
  } q_stat_t;

endpackage

`default_nettype wire

FILE: rtl/tbs_ram.sv
// tbs_ram: one copy of the texel store, one write and one read port
// depends on tbs_pkg for depth and widths; read data registered
`default_nettype none

module tbs_ram (
  input  wire logic                        clk,
  input  wire logic                        we,
  input  wire logic [tbs_pkg::ADDR_W-1:0]  waddr,
  input  wire logic [tbs_pkg::TEXEL_W-1:0] wdata,
  input  wire logic [tbs_pkg::ADDR_W-1:0]  raddr,
  output logic      [tbs_pkg::TEXEL_W-1:0] rdata
);

  logic [tbs_pkg::TEXEL_W-1:0] mem [tbs_pkg::TEX_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/tbs_addr.sv
// tbs_addr: scales u/v by size-1, registers position and weights,
// and forms the store requests; depends on tbs_pkg
`default_nettype none

module tbs_addr (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire tbs_pkg::ctl_t               ctl_in,
  input  wire logic [tbs_pkg::DIM_W-1:0]   tx_in,
  input  wire logic [tbs_pkg::DIM_W-1:0]   ty_in,
  input  wire logic [tbs_pkg::TEXEL_W-1:0] tv_in,
  input  wire logic [tbs_pkg::COORD_W-1:0] cu_in,
  input  wire logic [tbs_pkg::COORD_W-1:0] cv_in,
  input  wire logic [tbs_pkg::SIZE_W-1:0]  wc,
  input  wire logic [tbs_pkg::SIZE_W-1:0]  hc,
  output tbs_pkg::ctl_t                    ctl_out,
  output logic      [tbs_pkg::FRAC_W-1:0]  du_out,
  output logic      [tbs_pkg::FRAC_W-1:0]  dv_out,
  output tbs_pkg::ram_req_t                req
);

  tbs_pkg::ctl_t               ctl_r;
  logic [tbs_pkg::DIM_W-1:0]   tx_r, ty_r, xp_r, yp_r;
  logic [tbs_pkg::TEXEL_W-1:0] tv_r;
  logic [tbs_pkg::FRAC_W-1:0]  du_r, dv_r;
  logic [tbs_pkg::SCALE_W-1:0] su, sv;
  logic [tbs_pkg::DIM_W-1:0]   wm1, hm1, x1, y1;
  logic [tbs_pkg::SIZE_W-1:0]  xinc, yinc;
  logic                        is_sample;

  // size minus one always fits the coordinate width
  assign wm1 = tbs_pkg::DIM_W'(wc - tbs_pkg::SIZE_W'(1));
  assign hm1 = tbs_pkg::DIM_W'(hc - tbs_pkg::SIZE_W'(1));
  assign su  = tbs_pkg::SCALE_W'(cu_in) * tbs_pkg::SCALE_W'(wm1);
  assign sv  = tbs_pkg::SCALE_W'(cv_in) * tbs_pkg::SCALE_W'(hm1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    tx_r <= tx_in;
    ty_r <= ty_in;
    tv_r <= tv_in;
    xp_r <= su[tbs_pkg::SCALE_W-1 -: tbs_pkg::DIM_W];
    du_r <= su[tbs_pkg::COORD_W-1 -: tbs_pkg::FRAC_W];
    yp_r <= sv[tbs_pkg::SCALE_W-1 -: tbs_pkg::DIM_W];
    dv_r <= sv[tbs_pkg::COORD_W-1 -: tbs_pkg::FRAC_W];
  end

  // position stays below size, so the neighbour only wraps onto size
  assign xinc = tbs_pkg::SIZE_W'(xp_r) + tbs_pkg::SIZE_W'(1);
  assign yinc = tbs_pkg::SIZE_W'(yp_r) + tbs_pkg::SIZE_W'(1);
  assign x1   = (xinc == wc) ? '0 : xinc[tbs_pkg::DIM_W-1:0];
  assign y1   = (yinc == hc) ? '0 : yinc[tbs_pkg::DIM_W-1:0];

  assign is_sample = (ctl_r.op == tbs_pkg::OP_SAMPLE);

  always_comb begin
    req.we       = ctl_r.vld && (ctl_r.op == tbs_pkg::OP_WRITE);
    req.waddr    = {ty_r, tx_r};
    req.wdata    = tv_r;
    req.raddr[0] = is_sample ? {yp_r, xp_r} : {ty_r, tx_r};
    req.raddr[1] = {yp_r, x1};
    req.raddr[2] = {y1, xp_r};
    req.raddr[3] = {y1, x1};
  end

  assign ctl_out = ctl_r;
  assign du_out  = du_r;
  assign dv_out  = dv_r;

endmodule

`default_nettype wire

FILE: rtl/tbs_blend.sv
// tbs_blend: weight products, per-tap texel products and final sum
// depends on tbs_pkg; fed by the store copies' registered read data
`default_nettype none

module tbs_blend (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  input  wire tbs_pkg::ctl_t                           ctl_in,
  input  wire logic [tbs_pkg::FRAC_W-1:0]              du_in,
  input  wire logic [tbs_pkg::FRAC_W-1:0]              dv_in,
  input  wire logic [tbs_pkg::TAPS-1:0][tbs_pkg::TEXEL_W-1:0] texel,
  output logic                                         res_vld,
  output logic      [tbs_pkg::RES_W-1:0]               res_data
);

  tbs_pkg::ctl_t              ctl3_r, ctl4_r;
  logic [tbs_pkg::WGT_W-1:0]  wgt3_r  [tbs_pkg::TAPS];
  logic [tbs_pkg::PROD_W-1:0] prod4_r [tbs_pkg::TAPS];
  logic [tbs_pkg::TEXEL_W-1:0] pt4_r;
  logic [tbs_pkg::WONE_W-1:0] wx0, wy0, wx1, wy1;
  logic [tbs_pkg::PROD_W:0]   full [tbs_pkg::TAPS];
  logic [tbs_pkg::SUM_W-1:0]  sum;

  // one minus weight in 1.8
  assign wx0 = tbs_pkg::WONE_W'(1 << tbs_pkg::FRAC_W) - tbs_pkg::WONE_W'(du_in);
  assign wy0 = tbs_pkg::WONE_W'(1 << tbs_pkg::FRAC_W) - tbs_pkg::WONE_W'(dv_in);
  assign wx1 = tbs_pkg::WONE_W'(du_in);
  assign wy1 = tbs_pkg::WONE_W'(dv_in);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl3_r <= '0;
      ctl4_r <= '0;
    end else begin
      ctl3_r <= ctl_in;
      ctl4_r <= ctl3_r;
    end
  end

  always_ff @(posedge clk) begin
    wgt3_r[0] <= tbs_pkg::WGT_W'(wx0) * tbs_pkg::WGT_W'(wy0);
    wgt3_r[1] <= tbs_pkg::WGT_W'(wx1) * tbs_pkg::WGT_W'(wy0);
    wgt3_r[2] <= tbs_pkg::WGT_W'(wx0) * tbs_pkg::WGT_W'(wy1);
    wgt3_r[3] <= tbs_pkg::WGT_W'(wx1) * tbs_pkg::WGT_W'(wy1);
  end

  always_comb begin
    for (int i = 0; i < tbs_pkg::TAPS; i++) begin
      full[i] = (tbs_pkg::PROD_W+1)'(texel[i]) * (tbs_pkg::PROD_W+1)'(wgt3_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < tbs_pkg::TAPS; i++) begin
      prod4_r[i] <= full[i][tbs_pkg::PROD_W-1:0];
    end
    pt4_r <= texel[0];
  end

  assign sum = tbs_pkg::SUM_W'(prod4_r[0]) + tbs_pkg::SUM_W'(prod4_r[1])
             + tbs_pkg::SUM_W'(prod4_r[2]) + tbs_pkg::SUM_W'(prod4_r[3]);

  always_comb begin
    res_vld  = 1'b0;
    res_data = '0;
    case (ctl4_r.op)
      tbs_pkg::OP_POINT: begin
        res_vld  = ctl4_r.vld;
        res_data = {pt4_r, {(tbs_pkg::RES_W-tbs_pkg::TEXEL_W){1'b0}}};
      end
      tbs_pkg::OP_SAMPLE: begin
        res_vld  = ctl4_r.vld;
        res_data = ctl4_r.filt ? sum[tbs_pkg::FRAC_W +: tbs_pkg::RES_W] : '0;
      end
      default: begin
        res_vld  = 1'b0;
        res_data = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/tbs_outq.sv
// tbs_outq: small result queue between the pipeline and the output channel
// depends on tbs_pkg for depth and widths
`default_nettype none

module tbs_outq (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      push,
  input  wire logic [tbs_pkg::RES_W-1:0] push_data,
  output logic                           out_vld,
  input  wire logic                      pop,
  output logic      [tbs_pkg::RES_W-1:0] out_data,
  output tbs_pkg::q_stat_t               stat
);

  logic [tbs_pkg::RES_W-1:0]  mem [tbs_pkg::QDEPTH];
  logic [tbs_pkg::QPTR_W-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [tbs_pkg::QCNT_W-1:0] cnt_r, cnt_nxt;
  logic                       do_pop;

  assign do_pop = pop && (cnt_r != '0);

  always_comb begin
    wp_nxt  = push   ? wp_r + tbs_pkg::QPTR_W'(1) : wp_r;
    rp_nxt  = do_pop ? rp_r + tbs_pkg::QPTR_W'(1) : rp_r;
    cnt_nxt = cnt_r;
    case ({push, do_pop})
      2'b10:   cnt_nxt = cnt_r + tbs_pkg::QCNT_W'(1);
      2'b01:   cnt_nxt = cnt_r - tbs_pkg::QCNT_W'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp_r] <= push_data;
    end
  end

  assign out_vld    = (cnt_r != '0);
  assign out_data   = mem[rp_r];
  assign stat.count = cnt_r;
  assign stat.full  = (cnt_r == tbs_pkg::QCNT_W'(tbs_pkg::QDEPTH));

endmodule

`default_nettype wire

FILE: rtl/bilinear_texel_sampler.sv
// channel   | dir | ports                                  | contents
// in        | in  | in_tvalid in_tready in_tdata in_tuser  | one op item: write, point read, sample
// out       | out | out_tvalid out_tready out_tdata        | sample_value, 8.8 unsigned
// config    | in  | psel penable pwrite paddr pwdata ...   | tex_width at 0x0, tex_height at 0x4
//
// one item a cycle while in_tready is high; an accepted item passes the input
// register, address stage, store read and blend registers, then its result is queued
// rate is set by the four store copies, each giving one read and one write a cycle
// reset (rst_n, synchronous) clears pipeline valids, queue and size registers (both 1);
// the texel store holds no reset and needs no clearing pass
// acceptance is credit based: in_tready drops only when the result queue plus
// items in flight that will give a result reach the queue depth
//
// top level: register port, input register, coordinate/address stage,
// four texel store copies, blend stage and result queue; depends on tbs_pkg
`default_nettype none

module bilinear_texel_sampler (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // input channel
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // texel_x[7:0] texel_y[15:8] texel_value[23:16] coord_u[39:24]
  // coord_v[55:40] filter_on[56], zero above
  input  wire logic [tbs_pkg::IN_DATA_W-1:0]  in_tdata,
  // opcode[1:0]
  input  wire logic [tbs_pkg::IN_USER_W-1:0]  in_tuser,
  // result channel
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // sample_value[15:0]
  output logic      [tbs_pkg::RES_W-1:0]      out_tdata,
  // register port
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [tbs_pkg::APB_AW-1:0]     paddr,
  input  wire logic [tbs_pkg::APB_DW-1:0]     pwdata,
  output logic      [tbs_pkg::APB_DW-1:0]     prdata,
  output logic                                pready
);

  // size registers
  logic [tbs_pkg::SIZE_W-1:0] tex_w_r, tex_h_r, wc, hc;
  logic                       reg_wr;

  // input register (first stage)
  tbs_pkg::ctl_t               ctl1_r, ctl1_nxt;
  logic [tbs_pkg::DIM_W-1:0]   tx1_r, ty1_r;
  logic [tbs_pkg::TEXEL_W-1:0] tv1_r;
  logic [tbs_pkg::COORD_W-1:0] cu1_r, cv1_r;
  logic                        in_acc, gives_res;

  // later stages
  tbs_pkg::ctl_t               ctl2;
  logic [tbs_pkg::FRAC_W-1:0]  du2, dv2;
  tbs_pkg::ram_req_t           req;
  logic [tbs_pkg::TAPS-1:0][tbs_pkg::TEXEL_W-1:0] texel;
  logic                        res_vld;
  logic [tbs_pkg::RES_W-1:0]   res_data;
  tbs_pkg::q_stat_t            qstat;

  // credit counter: queued results plus result-giving items in flight
  logic [tbs_pkg::QCNT_W-1:0]  cred_r, cred_nxt;
  logic                        out_acc;

  // register port: word aligned, paddr[2] picks the register
  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tex_w_r <= tbs_pkg::SIZE_W'(1);
      tex_h_r <= tbs_pkg::SIZE_W'(1);
    end else if (reg_wr) begin
      if (paddr[2]) begin
        tex_h_r <= pwdata[tbs_pkg::SIZE_W-1:0];
      end else begin
        tex_w_r <= pwdata[tbs_pkg::SIZE_W-1:0];
      end
    end
  end

  assign prdata = paddr[2] ? tbs_pkg::APB_DW'(tex_h_r) : tbs_pkg::APB_DW'(tex_w_r);

  // sizes of zero act as one, above the store as the store size
  always_comb begin
    wc = tex_w_r;
    hc = tex_h_r;
    if (tex_w_r == '0) begin
      wc = tbs_pkg::SIZE_W'(1);
    end else if (tex_w_r > tbs_pkg::SIZE_W'(tbs_pkg::MAX_DIM)) begin
      wc = tbs_pkg::SIZE_W'(tbs_pkg::MAX_DIM);
    end
    if (tex_h_r == '0) begin
      hc = tbs_pkg::SIZE_W'(1);
    end else if (tex_h_r > tbs_pkg::SIZE_W'(tbs_pkg::MAX_DIM)) begin
      hc = tbs_pkg::SIZE_W'(tbs_pkg::MAX_DIM);
    end
  end

  // acceptance
  assign in_tready = (cred_r < tbs_pkg::QCNT_W'(tbs_pkg::QDEPTH));
  assign in_acc    = in_tvalid && in_tready;
  assign gives_res = (in_tuser == tbs_pkg::OP_POINT) || (in_tuser == tbs_pkg::OP_SAMPLE);
  assign out_acc   = out_tvalid && out_tready;

  always_comb begin
    ctl1_nxt.vld  = in_acc;
    ctl1_nxt.op   = tbs_pkg::op_t'(in_tuser);
    ctl1_nxt.filt = in_tdata[56];
  end

  always_comb begin
    cred_nxt = cred_r;
    case ({in_acc && gives_res, out_acc})
      2'b10:   cred_nxt = cred_r + tbs_pkg::QCNT_W'(1);
      2'b01:   cred_nxt = cred_r - tbs_pkg::QCNT_W'(1);
      default: cred_nxt = cred_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
      cred_r <= '0;
    end else begin
      ctl1_r <= ctl1_nxt;
      cred_r <= cred_nxt;
    end
  end

  // payload of the input register
  always_ff @(posedge clk) begin
    tx1_r <= in_tdata[7:0];
    ty1_r <= in_tdata[15:8];
    tv1_r <= in_tdata[23:16];
    cu1_r <= in_tdata[39:24];
    cv1_r <= in_tdata[55:40];
  end

  // scale coordinates, form neighbour addresses
  tbs_addr u_addr (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl_in  (ctl1_r),
    .tx_in   (tx1_r),
    .ty_in   (ty1_r),
    .tv_in   (tv1_r),
    .cu_in   (cu1_r),
    .cv_in   (cv1_r),
    .wc      (wc),
    .hc      (hc),
    .ctl_out (ctl2),
    .du_out  (du2),
    .dv_out  (dv2),
    .req     (req)
  );

  // four identical store copies, one per tap; writes go to all of them in
  // the same stage as the reads, so a later item always sees an earlier write
  for (genvar g = 0; g < tbs_pkg::TAPS; g++) begin : g_copy
    tbs_ram u_ram (
      .clk   (clk),
      .we    (req.we),
      .waddr (req.waddr),
      .wdata (req.wdata),
      .raddr (req.raddr[g]),
      .rdata (texel[g])
    );
  end

  // weighting and sum
  tbs_blend u_blend (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl_in   (ctl2),
    .du_in    (du2),
    .dv_in    (dv2),
    .texel    (texel),
    .res_vld  (res_vld),
    .res_data (res_data)
  );

  // result queue decouples the pipeline from output stalls
  tbs_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_vld),
    .push_data (res_data),
    .out_vld   (out_tvalid),
    .pop       (out_tready),
    .out_data  (out_tdata),
    .stat      (qstat)
  );

  // credits never exceed the queue depth
  a_cred_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cred_r <= tbs_pkg::QCNT_W'(tbs_pkg::QDEPTH))
    else $error("credit count above queue depth");

  // a result is never pushed into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld |-> !qstat.full)
    else $error("result pushed into full queue");

  // queued results are always covered by credits
  a_cred_cover: assert property (@(posedge clk) disable iff (!rst_n)
    qstat.count <= cred_r)
    else $error("queue holds more results than credits");

  // a point read or sample accepted now reaches the queue through the pipeline registers
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && gives_res) |-> ##4 res_vld)
    else $error("result missing four cycles after acceptance");

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
// tb_top: self-checking bench for bilinear_texel_sampler, random and directed op items
// predicts point reads and bilinear samples in a small scoreboard class; needs tbs_pkg

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // register indexes on the config port
  localparam int REG_TEX_WIDTH  = 0;
  localparam int REG_TEX_HEIGHT = 1;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned DRAIN_LIMIT   = 20000;
  localparam int unsigned SETTLE_CYCLES = 10;
  localparam int unsigned NUM_PHASES    = 12;
  localparam int unsigned PHASE_ITEMS   = 85;
  localparam int unsigned CALM_PHASE    = 5;

  // one op item as the block sees it
  typedef struct {
    tbs_pkg::op_t op;
    bit [7:0] tx;
    bit [7:0] ty;
    bit [7:0] tv;
    bit [15:0] cu;
    bit [15:0] cv;
    bit       filt;
  } sampler_item_t;

  // mirrors the texel store and size registers, holds the sample values still owed
  class sampler_scoreboard;
    bit [7:0]  texture [0:65535];
    bit [8:0]  width_reg;
    bit [8:0]  height_reg;
    bit [15:0] pending_values [$];
    int unsigned failures;

    function new();
      width_reg  = 9'd1;
      height_reg = 9'd1;
      failures   = 0;
    endfunction

    function void set_register(int idx, bit [8:0] value);
      if (idx == REG_TEX_WIDTH) width_reg = value;
      else if (idx == REG_TEX_HEIGHT) height_reg = value;
    endfunction

    // zero counts as one, anything past the store as the full store
    function int unsigned used_dim(bit [8:0] d);
      if (d == 0) return 1;
      if (d > tbs_pkg::MAX_DIM) return tbs_pkg::MAX_DIM;
      return d;
    endfunction

    // integer positions, wrapped neighbours and sub-texel weights of a sample
    function void neighbour_taps(input bit [15:0] cu, input bit [15:0] cv,
                                 output bit [7:0] x0, output bit [7:0] x1,
                                 output bit [7:0] y0, output bit [7:0] y1,
                                 output bit [7:0] du, output bit [7:0] dv);
      int unsigned w, h, pu, pv;
      w  = used_dim(width_reg);
      h  = used_dim(height_reg);
      pu = cu * (w - 1);
      pv = cv * (h - 1);
      x0 = 8'((pu >> 16) % w);
      y0 = 8'((pv >> 16) % h);
      x1 = 8'((int'(x0) + 1) % w);
      y1 = 8'((int'(y0) + 1) % h);
      du = 8'(pu >> 8);
      dv = 8'(pv >> 8);
    endfunction

    function void note_item(sampler_item_t it);
      bit [7:0] x0, x1, y0, y1, du, dv;
      int unsigned wx0, wy0, sum;
      case (it.op)
        tbs_pkg::OP_WRITE: texture[{it.ty, it.tx}] = it.tv;
        tbs_pkg::OP_POINT: pending_values.push_back({texture[{it.ty, it.tx}], 8'h00});
        tbs_pkg::OP_SAMPLE: begin
          if (!it.filt) begin
            pending_values.push_back(16'h0000);
          end else begin
            neighbour_taps(it.cu, it.cv, x0, x1, y0, y1, du, dv);
            wx0 = 256 - du;
            wy0 = 256 - dv;
            sum = wx0 * wy0 * texture[{y0, x0}] + du * wy0 * texture[{y0, x1}]
                + wx0 * dv * texture[{y1, x0}] + du * dv * texture[{y1, x1}];
            pending_values.push_back(16'(sum >> 8));
          end
        end
        default: ; // reserved op, ignored by the block
      endcase
    endfunction

    function void check_result(bit [15:0] got);
      bit [15:0] want;
      if (pending_values.size() == 0) begin
        $error("sample_value: no result expected, got %0d", got);
        failures++;
        return;
      end
      want = pending_values.pop_front();
      if (got !== want) begin
        $error("sample_value: expected %0d, got %0d", want, got);
        failures++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  sampler_scoreboard sb = new();

  // texels written so far, so that no read ever touches an unwritten one
  bit texel_written [0:65535];
  // when set neither side idles
  bit calm = 1'b0;
  int unsigned cycle_count = 0;
  // every item taken by the block, filler writes included
  int unsigned items_sent = 0;

  // size settings per phase, extremes and out-of-range values among them
  int phase_w [0:11] = '{4, 256, 0, 511, 2, 1, 256, 7, 16, 3, 256, 5};
  int phase_h [0:11] = '{3, 256, 0, 300, 2, 256, 1, 13, 16, 9, 256, 1};

  bilinear_texel_sampler u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    // texel_x, texel_y, texel_value, coord_u, coord_v, filter_on, zero above
    .in_tdata   (in_tdata),
    // opcode
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    // sample_value
    .out_tdata  (out_tdata),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #5 clk = ~clk;

  // hard stop in case the block hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("bilinear_texel_sampler verification failed");
      $finish;
    end
  end

  // result side: check on handshake, then stall at random unless calm
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
    out_tready <= calm || ($urandom_range(99) >= 30);
  end

  function automatic sampler_item_t make_item(tbs_pkg::op_t op, bit [7:0] tx, bit [7:0] ty,
                                              bit [7:0] tv, bit [15:0] cu,
                                              bit [15:0] cv, bit filt);
    sampler_item_t it;
    it.op = op;
    it.tx = tx;
    it.ty = ty;
    it.tv = tv;
    it.cu = cu;
    it.cv = cv;
    it.filt = filt;
    return it;
  endfunction

  function automatic sampler_item_t random_fields();
    return make_item(tbs_pkg::op_t'($urandom_range(3)), 8'($urandom), 8'($urandom),
                     8'($urandom), 16'($urandom), 16'($urandom), 1'($urandom));
  endfunction

  // mostly samples and reads inside the texture in use, with some noise
  function automatic sampler_item_t random_item();
    sampler_item_t it;
    int unsigned roll, w, h;
    it   = random_fields();
    w    = sb.used_dim(sb.width_reg);
    h    = sb.used_dim(sb.height_reg);
    roll = $urandom_range(99);
    if (roll < 30) it.op = tbs_pkg::OP_WRITE;
    else if (roll < 60) it.op = tbs_pkg::OP_POINT;
    else if (roll < 95) it.op = tbs_pkg::OP_SAMPLE;
    else it.op = tbs_pkg::OP_RSVD;
    if ($urandom_range(99) < 60) begin
      it.tx = 8'($urandom_range(w - 1));
      it.ty = 8'($urandom_range(h - 1));
    end
    // coordinate extremes now and then
    if ($urandom_range(9) == 0) it.cu = $urandom_range(1) ? 16'hFFFF : 16'h0000;
    if ($urandom_range(9) == 0) it.cv = $urandom_range(1) ? 16'hFFFF : 16'h0000;
    it.filt = ($urandom_range(99) < 85);
    return it;
  endfunction

  // present one item, idling at random first, and note it once taken
  task automatic send_item(input sampler_item_t it);
    while (!calm && $urandom_range(99) < 30) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'b0, it.filt, it.cv, it.cu, it.tv, it.ty, it.tx};
    in_tuser  <= it.op;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (it.op == tbs_pkg::OP_WRITE) texel_written[{it.ty, it.tx}] = 1'b1;
    sb.note_item(it);
    items_sent++;
  endtask

  // a texel about to be read gets a random value first if it has none yet
  task automatic make_written(input bit [7:0] x, input bit [7:0] y);
    sampler_item_t wr;
    if (!texel_written[{y, x}]) begin
      wr    = random_fields();
      wr.op = tbs_pkg::OP_WRITE;
      wr.tx = x;
      wr.ty = y;
      send_item(wr);
    end
  endtask

  task automatic issue(input sampler_item_t it);
    bit [7:0] x0, x1, y0, y1, du, dv;
    if (it.op == tbs_pkg::OP_POINT) make_written(it.tx, it.ty);
    if (it.op == tbs_pkg::OP_SAMPLE && it.filt) begin
      sb.neighbour_taps(it.cu, it.cv, x0, x1, y0, y1, du, dv);
      make_written(x0, y0);
      make_written(x1, y0);
      make_written(x0, y1);
      make_written(x1, y1);
    end
    send_item(it);
  endtask

  // sender holds off until every owed result is in and trailing writes are done
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (sb.pending_values.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // setup then access cycle; the register takes the value at the access edge
  task automatic write_register(input int idx, input bit [8:0] value);
    wait_idle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(idx * 4);
    pwdata  <= {23'b0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_register(idx, value);
  endtask

  initial begin
    int unsigned phase_start;
    sampler_item_t it;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part at the reset size of one texel
    issue(make_item(tbs_pkg::OP_WRITE, 8'd0, 8'd0, 8'hFF, 16'h0000, 16'h0000, 1'b0));
    issue(make_item(tbs_pkg::OP_POINT, 8'd0, 8'd0, 8'h00, 16'hFFFF, 16'hFFFF, 1'b1));
    issue(make_item(tbs_pkg::OP_SAMPLE, 8'd0, 8'd0, 8'h00, 16'h0000, 16'h0000, 1'b1));
    issue(make_item(tbs_pkg::OP_SAMPLE, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b1));
    // filtering off gives zero whatever the texels hold
    issue(make_item(tbs_pkg::OP_SAMPLE, 8'd0, 8'd0, 8'h00, 16'h8000, 16'h8000, 1'b0));
    // reserved op, must give nothing
    it    = random_fields();
    it.op = tbs_pkg::OP_RSVD;
    issue(it);
    // store corners, addressed regardless of the size registers
    issue(make_item(tbs_pkg::OP_WRITE, 8'hFF, 8'hFF, 8'h00, 16'hFFFF, 16'h0000, 1'b1));
    issue(make_item(tbs_pkg::OP_POINT, 8'hFF, 8'hFF, 8'h00, 16'h0000, 16'h0000, 1'b0));
    issue(make_item(tbs_pkg::OP_WRITE, 8'hFF, 8'h00, 8'hA5, 16'h0000, 16'hFFFF, 1'b0));
    issue(make_item(tbs_pkg::OP_POINT, 8'hFF, 8'h00, 8'h00, 16'h0000, 16'h0000, 1'b0));
    issue(make_item(tbs_pkg::OP_WRITE, 8'h00, 8'hFF, 8'h5A, 16'h0000, 16'h0000, 1'b0));
    issue(make_item(tbs_pkg::OP_POINT, 8'h00, 8'hFF, 8'h00, 16'h0000, 16'h0000, 1'b0));
    // overwrite followed straight away by a read of the same texel
    issue(make_item(tbs_pkg::OP_WRITE, 8'd0, 8'd0, 8'h00, 16'h0000, 16'h0000, 1'b0));
    issue(make_item(tbs_pkg::OP_POINT, 8'd0, 8'd0, 8'h00, 16'h0000, 16'h0000, 1'b0));

    // random phases, each setting the texture size first; filler writes count too
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_register(REG_TEX_WIDTH, 9'(phase_w[p]));
      write_register(REG_TEX_HEIGHT, 9'(phase_h[p]));
      calm = (p == CALM_PHASE);
      phase_start = items_sent;
      // coordinate extremes at every size
      issue(make_item(tbs_pkg::OP_SAMPLE, 8'd0, 8'd0, 8'd0, 16'h0000, 16'h0000, 1'b1));
      issue(make_item(tbs_pkg::OP_SAMPLE, 8'd0, 8'd0, 8'd0, 16'hFFFF, 16'hFFFF, 1'b1));
      issue(make_item(tbs_pkg::OP_SAMPLE, 8'd0, 8'd0, 8'd0, 16'hFFFF, 16'h0000, 1'b1));
      while (items_sent - phase_start < PHASE_ITEMS) begin
        it = random_item();
        issue(it);
      end
    end
    calm = 1'b0;

    // let the last results come out, then watch for strays
    in_tvalid <= 1'b0;
    for (int n = 0; n < DRAIN_LIMIT && sb.pending_values.size() != 0; n++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.pending_values.size() != 0) begin
      $error("sample_value: %0d expected results never came", sb.pending_values.size());
      sb.failures++;
    end

    if (sb.failures == 0) begin
      $display("bilinear_texel_sampler verification clean");
    end else begin
      $display("bilinear_texel_sampler verification failed");
    end
    $finish;
  end

endmodule
